// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int CNT_BITS    = $clog2(TABLE_SLOTS + 1);
  localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ZERO_KEY  = 2'd3;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] found_value;
  } out_word_t;

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] slot;
  } hash_rsp_t;

endpackage

// ===== rtl/lpht_ram.sv =====
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lpht_hash.sv =====
`timescale 1ns / 1ps
module lpht_hash
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  output hash_rsp_t           rsp
);

  // 64-bit finalizer, each 64x64 low product built from three 32x32 products
  function automatic logic [63:0] xs33(input logic [63:0] x);
    return x ^ (x >> 33);
  endfunction

  logic        busy_r;
  logic        done_r;
  logic        rnd_r;
  logic [1:0]  step_r;
  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;

  logic [63:0] mix_c;
  logic [31:0] mul_a;
  logic [31:0] mul_c;
  logic [63:0] mul_p;
  logic [31:0] acc_hi_sum;

  assign mix_c      = rnd_r ? MIX_C2 : MIX_C1;
  assign mul_a      = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign mul_c      = (step_r == 2'd1) ? mix_c[63:32] : mix_c[31:0];
  assign mul_p      = mul_a * mul_c;
  assign acc_hi_sum = acc_r[63:32] + prod_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 1'b0;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (rnd_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            rnd_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= xs33(64'(key));
    end else if (busy_r) begin
      prod_r <= mul_p;
      case (step_r)
        2'd1: acc_r <= prod_r;
        2'd2: acc_r[63:32] <= acc_hi_sum;
        2'd3: a_r <= xs33({acc_hi_sum, acc_r[31:0]});
        default: ;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.slot = a_r[SLOT_BITS-1:0];

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("hash restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r) && $past(rnd_r)) else $error("hash done out of sequence");
`endif

endmodule

// ===== rtl/linear_probe_hash_table_top.sv =====
// Open-addressing key/value table with linear probing, 64 slots. An insert
// (cmd 0) stores the pair in the first empty slot at or after the key's hashed
// home slot; a lookup (cmd 1) returns the value of the first matching key met
// before an empty slot. Key zero marks an empty slot: inserting it returns
// status 3, looking it up returns not found. Inserting into a full table
// returns status 2. The table is empty after reset. Items are handled one at
// a time. A zero key or a full insert goes straight from idle to done. Any
// other item waits on the multi-cycle hash (8 steps on one shared 32x32
// multiplier plus its done strobe), then each probe passes through a read
// state for the slot memory's registered read and a check state for the compare;
// the done state loads the result register and returns to idle. A result held
// off by out_ready holds the item in done until the output register frees.
`timescale 1ns / 1ps
module linear_probe_hash_table_top
  import lpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic                   cmd_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [VALUE_BITS-1:0]  value_r;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [SLOT_BITS-1:0]   probe_r;
  logic [CNT_BITS-1:0]    count_r;
  logic [TABLE_SLOTS-1:0] slot_valid_r;
  logic                   vld_rd_r;
  logic [1:0]             res_status_r;
  logic [VALUE_BITS-1:0]  res_value_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;

  hash_rsp_t              hash_rsp;
  logic                   in_fire;
  logic                   hash_start;
  logic                   early_done;
  logic [1:0]             early_status;
  logic [ENTRY_BITS-1:0]  rd_entry;
  logic [KEY_BITS-1:0]    entry_key;
  logic                   hit_empty;
  logic                   hit_key;
  logic                   last_probe;
  logic                   chk_finish;
  logic [1:0]             chk_status;
  logic                   mem_we;
  logic                   out_free;
  logic [SLOT_BITS-1:0]   slot_next;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // requests that never touch the table
  always_comb begin
    early_done   = 1'b0;
    early_status = ST_OK;
    if (in_data.cmd == CMD_INSERT && in_data.key == '0) begin
      early_done   = 1'b1;
      early_status = ST_ZERO_KEY;
    end else if (in_data.cmd == CMD_INSERT && count_r == CNT_BITS'(TABLE_SLOTS)) begin
      early_done   = 1'b1;
      early_status = ST_FULL;
    end else if (in_data.cmd == CMD_LOOKUP && in_data.key == '0) begin
      early_done   = 1'b1;
      early_status = ST_NOT_FOUND;
    end
  end

  assign hash_start = in_fire && !early_done;

  lpht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_data.key),
    .rsp   (hash_rsp)
  );

  lpht_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_r),
    .wdata ({key_r, value_r}),
    .raddr (slot_r),
    .rdata (rd_entry)
  );

  // a slot never written reads as empty
  assign entry_key  = vld_rd_r ? rd_entry[ENTRY_BITS-1 -: KEY_BITS] : '0;
  assign hit_empty  = (entry_key == '0);
  assign hit_key    = (entry_key == key_r);
  assign last_probe = (probe_r == SLOT_BITS'(TABLE_SLOTS - 1));
  assign slot_next  = (slot_r == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : slot_r + 1'b1;

  assign chk_finish = hit_empty || last_probe || (cmd_r == CMD_LOOKUP && hit_key);
  assign mem_we     = (state_r == S_CHECK) && (cmd_r == CMD_INSERT) && hit_empty;

  always_comb begin
    if (cmd_r == CMD_INSERT) begin
      chk_status = hit_empty ? ST_OK : ST_FULL;
    end else if (hit_empty) begin
      chk_status = ST_NOT_FOUND;
    end else if (hit_key) begin
      chk_status = ST_OK;
    end else begin
      chk_status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = early_done ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_rsp.done) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = chk_finish ? S_DONE : S_READ;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        count_r              <= count_r + 1'b1;
        slot_valid_r[slot_r] <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r        <= in_data.cmd;
      key_r        <= in_data.key;
      value_r      <= in_data.value;
      res_status_r <= early_status;
      res_value_r  <= '0;
    end
    if (state_r == S_HASH && hash_rsp.done) begin
      slot_r  <= hash_rsp.slot;
      probe_r <= '0;
    end
    if (state_r == S_READ) begin
      vld_rd_r <= slot_valid_r[slot_r];
    end
    if (state_r == S_CHECK) begin
      if (chk_finish) begin
        res_status_r <= chk_status;
        res_value_r  <= (cmd_r == CMD_LOOKUP && !hit_empty && hit_key) ?
                        rd_entry[VALUE_BITS-1:0] : '0;
      end else begin
        slot_r  <= slot_next;
        probe_r <= probe_r + 1'b1;
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.status      <= res_status_r;
      out_data_r.found_value <= res_value_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == 32'(count_r)) else $error("entry count out of step");
  a_write_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !slot_valid_r[slot_r]) else $error("insert overwrote an occupied slot");
  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> count_r != CNT_BITS'(TABLE_SLOTS)) else $error("insert into full table");
  a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    hash_rsp.done |-> state_r == S_HASH) else $error("hash finished outside hash wait");
`endif

endmodule
